// ===== src/bpsd_pkg.sv =====
// Shared types and constants for the BMP pixel stream decoder.
package bpsd_pkg;

   // Image size limits and coordinate widths
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int COORD_W    = 12;

   // Header layout (byte positions within the 54-byte header)
   localparam int HDR_LEN  = 54;
   localparam int HDR_LAST = HDR_LEN - 1;
   localparam int OFS_BASE = 10;
   localparam int WID_BASE = 18;
   localparam int HGT_BASE = 22;
   localparam int PLN_BASE = 26;
   localparam int BPP_BASE = 28;
   localparam int CMP_BASE = 30;

   localparam logic [15:0] BPP_RGB  = 16'd24;
   localparam logic [15:0] BPP_RGBA = 16'd32;

   // Queue sizes
   localparam int CMD_DEPTH = 4;
   localparam int CMD_AW    = $clog2(CMD_DEPTH);
   localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);
   localparam int RSP_DEPTH = 4;
   localparam int RSP_AW    = $clog2(RSP_DEPTH);
   localparam int RSP_CW    = $clog2(RSP_DEPTH + 1);

   // Parser phase of the front end
   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXELS,
      PH_ERROR
   } phase_type;

   // Command from front to back
   typedef enum logic [1:0] {
      OP_START,
      OP_PIXEL,
      OP_ERROR
   } cmd_op_type;

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_SHORT  = 3'd1,
      ERR_FORMAT = 3'd2,
      ERR_DEPTH  = 3'd3,
      ERR_SIZE   = 3'd4,
      ERR_TRUNC  = 3'd5
   } err_type;

   typedef struct packed {
      cmd_op_type         op;
      logic [7:0]         data;
      logic               eof;
      err_type            err;
      logic [COL_W-1:0]   wm1;
      logic [ROW_W-1:0]   hm1;
      logic               alpha;
   } cmd_type;

   typedef struct packed {
      kind_type             kind;
      err_type              err;
      logic [7:0]           red;
      logic [7:0]           green;
      logic [7:0]           blue;
      logic [7:0]           alpha;
      logic                 has_alpha;
      logic [COORD_W-1:0]   row;
      logic [COORD_W-1:0]   col;
   } rsp_type;

   // Up to two results written into the result queue per cycle
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } rsp_push_type;

endpackage

// ===== src/bmp_pixel_stream_decoder_core.sv =====
// Top level of the BMP pixel stream decoder (24/32-bit uncompressed).
//
//  channel   | ports                                   | flow control
//  ----------+-----------------------------------------+----------------------
//  byte in   | req_data_byte, req_end_of_file          | req_push / req_full
//  result    | rsp_result_kind .. rsp_out_col          | rsp_empty / rsp_pop
//
// One byte is taken per cycle while req_full is low; the front end classifies
// it in that cycle and the back end turns the queued command into zero, one
// or two results. Throughput is set by the result port: a byte completing the
// image (pixel plus completion) or a pixel of a short file queues two results.
// Synchronous reset empties both queues and returns the parser to the header.
// req_full follows the command queue; the back end stalls while the result
// queue has fewer than two free entries.
module bmp_pixel_stream_decoder_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  logic [7:0]   req_data_byte,
   input  logic         req_end_of_file,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [1:0]   rsp_result_kind,
   output logic [2:0]   rsp_error_code,
   output logic [7:0]   rsp_red,
   output logic [7:0]   rsp_green,
   output logic [7:0]   rsp_blue,
   output logic [7:0]   rsp_alpha,
   output logic         rsp_has_alpha,
   output logic [11:0]  rsp_out_row,
   output logic [11:0]  rsp_out_col
);

   logic                   cmd_push, cmd_full, cmd_empty, cmd_pop, rsp_room;
   bpsd_pkg::cmd_type      cmd_in, cmd_head;
   bpsd_pkg::rsp_push_type rsp_wr;
   bpsd_pkg::rsp_type      rsp_head;

   assign req_full = cmd_full;

   bpsd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_data_byte   (req_data_byte),
      .req_end_of_file (req_end_of_file),
      .cmd_full        (cmd_full),
      .cmd_push        (cmd_push),
      .cmd_data        (cmd_in)
   );

   bpsd_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .head      (cmd_head)
   );

   bpsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_room  (rsp_room),
      .rsp_wr    (rsp_wr)
   );

   bpsd_rsp_fifo u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .rsp_wr (rsp_wr),
      .room   (rsp_room),
      .pop    (rsp_pop),
      .empty  (rsp_empty),
      .head   (rsp_head)
   );

   // Result ports
   assign rsp_result_kind = rsp_head.kind;
   assign rsp_error_code  = rsp_head.err;
   assign rsp_red         = rsp_head.red;
   assign rsp_green       = rsp_head.green;
   assign rsp_blue        = rsp_head.blue;
   assign rsp_alpha       = rsp_head.alpha;
   assign rsp_has_alpha   = rsp_head.has_alpha;
   assign rsp_out_row     = rsp_head.row;
   assign rsp_out_col     = rsp_head.col;

endmodule

// ===== src/bpsd_front.sv =====
// Front end: header capture, header check, offset skip and byte classification.
module bpsd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_data_byte,
   input  logic                req_end_of_file,
   input  logic                cmd_full,
   output logic                cmd_push,
   output bpsd_pkg::cmd_type   cmd_data
);

   bpsd_pkg::phase_type phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [15:0] planes_ff, planes_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] comp_ff, comp_in;

   logic              accept;
   logic [5:0]        hpos;
   bpsd_pkg::err_type hdr_err;

   assign accept = req_push && !cmd_full;
   assign hpos   = pos_ff[5:0];

   // Phase and position registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bpsd_pkg::PH_HEADER;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   // Captured header fields
   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      planes_ff <= planes_in;
      bits_ff   <= bits_in;
      comp_ff   <= comp_in;
   end

   // Header byte capture, little-endian
   always_comb begin
      offset_in = offset_ff;
      width_in  = width_ff;
      height_in = height_ff;
      planes_in = planes_ff;
      bits_in   = bits_ff;
      comp_in   = comp_ff;
      if (accept && phase_ff == bpsd_pkg::PH_HEADER) begin
         if (hpos inside {[bpsd_pkg::OFS_BASE:bpsd_pkg::OFS_BASE+3]})
            offset_in[{2'(hpos - 6'(bpsd_pkg::OFS_BASE)), 3'b000} +: 8] = req_data_byte;
         if (hpos inside {[bpsd_pkg::WID_BASE:bpsd_pkg::WID_BASE+3]})
            width_in[{2'(hpos - 6'(bpsd_pkg::WID_BASE)), 3'b000} +: 8] = req_data_byte;
         if (hpos inside {[bpsd_pkg::HGT_BASE:bpsd_pkg::HGT_BASE+3]})
            height_in[{2'(hpos - 6'(bpsd_pkg::HGT_BASE)), 3'b000} +: 8] = req_data_byte;
         if (hpos inside {[bpsd_pkg::PLN_BASE:bpsd_pkg::PLN_BASE+1]})
            planes_in[{1'(hpos - 6'(bpsd_pkg::PLN_BASE)), 3'b000} +: 8] = req_data_byte;
         if (hpos inside {[bpsd_pkg::BPP_BASE:bpsd_pkg::BPP_BASE+1]})
            bits_in[{1'(hpos - 6'(bpsd_pkg::BPP_BASE)), 3'b000} +: 8] = req_data_byte;
         if (hpos inside {[bpsd_pkg::CMP_BASE:bpsd_pkg::CMP_BASE+3]})
            comp_in[{2'(hpos - 6'(bpsd_pkg::CMP_BASE)), 3'b000} +: 8] = req_data_byte;
      end
   end

   // Header check on the completed header, in priority order
   always_comb begin
      if (comp_in != 32'd0 || planes_in != 16'd1)
         hdr_err = bpsd_pkg::ERR_FORMAT;
      else if (bits_in != bpsd_pkg::BPP_RGB && bits_in != bpsd_pkg::BPP_RGBA)
         hdr_err = bpsd_pkg::ERR_DEPTH;
      else if (width_in == 32'd0 || width_in > 32'(bpsd_pkg::MAX_WIDTH))
         hdr_err = bpsd_pkg::ERR_SIZE;
      else if (height_in == 32'd0 || height_in > 32'(bpsd_pkg::MAX_HEIGHT))
         hdr_err = bpsd_pkg::ERR_SIZE;
      else if (offset_in < 32'(bpsd_pkg::HDR_LEN))
         hdr_err = bpsd_pkg::ERR_SIZE;
      else
         hdr_err = bpsd_pkg::ERR_NONE;
   end

   // Next phase and command to the back end
   always_comb begin
      phase_in          = phase_ff;
      pos_in            = pos_ff;
      cmd_push          = 1'b0;
      cmd_data          = '0;
      cmd_data.op       = bpsd_pkg::OP_PIXEL;
      cmd_data.err      = bpsd_pkg::ERR_NONE;
      cmd_data.data     = req_data_byte;
      cmd_data.eof      = req_end_of_file;
      cmd_data.wm1      = COL_W_CAST(width_in - 32'd1);
      cmd_data.hm1      = ROW_W_CAST(height_in - 32'd1);
      cmd_data.alpha    = (bits_in == bpsd_pkg::BPP_RGBA);
      if (accept) begin
         case (phase_ff)
            bpsd_pkg::PH_HEADER: begin
               pos_in = pos_ff + 32'd1;
               if (hpos == 6'(bpsd_pkg::HDR_LAST)) begin
                  if (hdr_err != bpsd_pkg::ERR_NONE) begin
                     cmd_push     = 1'b1;
                     cmd_data.op  = bpsd_pkg::OP_ERROR;
                     cmd_data.err = hdr_err;
                     phase_in     = bpsd_pkg::PH_ERROR;
                  end else if (req_end_of_file) begin
                     cmd_push     = 1'b1;
                     cmd_data.op  = bpsd_pkg::OP_ERROR;
                     cmd_data.err = bpsd_pkg::ERR_TRUNC;
                  end else begin
                     cmd_push    = 1'b1;
                     cmd_data.op = bpsd_pkg::OP_START;
                     phase_in    = (offset_in == 32'(bpsd_pkg::HDR_LEN)) ?
                                   bpsd_pkg::PH_PIXELS : bpsd_pkg::PH_SKIP;
                  end
               end else if (req_end_of_file) begin
                  cmd_push     = 1'b1;
                  cmd_data.op  = bpsd_pkg::OP_ERROR;
                  cmd_data.err = bpsd_pkg::ERR_SHORT;
               end
            end
            bpsd_pkg::PH_SKIP: begin
               // position stays below the offset here, so no saturation is needed
               pos_in = pos_ff + 32'd1;
               if (pos_in >= offset_ff) phase_in = bpsd_pkg::PH_PIXELS;
               if (req_end_of_file) begin
                  cmd_push     = 1'b1;
                  cmd_data.op  = bpsd_pkg::OP_ERROR;
                  cmd_data.err = bpsd_pkg::ERR_TRUNC;
               end
            end
            bpsd_pkg::PH_PIXELS: begin
               cmd_push = 1'b1;
            end
            default: begin
            end
         endcase
         // end of file rearms the parser
         if (req_end_of_file) begin
            phase_in = bpsd_pkg::PH_HEADER;
            pos_in   = '0;
         end
      end
   end

   function automatic logic [bpsd_pkg::COL_W-1:0] COL_W_CAST(input logic [31:0] v);
      return v[bpsd_pkg::COL_W-1:0];
   endfunction

   function automatic logic [bpsd_pkg::ROW_W-1:0] ROW_W_CAST(input logic [31:0] v);
      return v[bpsd_pkg::ROW_W-1:0];
   endfunction

endmodule

// ===== src/bpsd_cmd_fifo.sv =====
// Short command queue between the front and back ends.
module bpsd_cmd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bpsd_pkg::cmd_type   push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output bpsd_pkg::cmd_type   head
);

   bpsd_pkg::cmd_type entry_ff [bpsd_pkg::CMD_DEPTH];
   logic [bpsd_pkg::CMD_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bpsd_pkg::CMD_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bpsd_pkg::CMD_CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == bpsd_pkg::CMD_CW'(bpsd_pkg::CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== src/bpsd_back.sv =====
// Back end: pixel assembly, row padding, coordinates and result generation.
module bpsd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_empty,
   input  bpsd_pkg::cmd_type      cmd_head,
   output logic                   cmd_pop,
   input  logic                   rsp_room,
   output bpsd_pkg::rsp_push_type rsp_wr
);

   logic                        active_ff, active_in;
   logic [bpsd_pkg::COL_W-1:0]  wm1_ff, wm1_in;
   logic [bpsd_pkg::ROW_W-1:0]  hm1_ff, hm1_in;
   logic                        alpha_ff, alpha_in;
   logic [1:0]                  bip_ff, bip_in;
   logic [23:0]                 held_ff, held_in;
   logic [bpsd_pkg::COL_W-1:0]  col_ff, col_in;
   logic [bpsd_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [1:0]                  pad_ff, pad_in;

   bpsd_pkg::rsp_type pix_rsp, done_rsp, trunc_rsp, err_rsp;
   logic [bpsd_pkg::ROW_W-1:0] flip_row;

   assign cmd_pop  = !cmd_empty && rsp_room;
   assign flip_row = hm1_ff - row_ff;

   // Candidate results
   always_comb begin
      pix_rsp           = '0;
      pix_rsp.kind      = bpsd_pkg::KIND_PIXEL;
      pix_rsp.err       = bpsd_pkg::ERR_NONE;
      pix_rsp.green     = held_ff[15:8];
      pix_rsp.blue      = held_ff[7:0];
      pix_rsp.has_alpha = alpha_ff;
      pix_rsp.row       = bpsd_pkg::COORD_W'(flip_row);
      pix_rsp.col       = bpsd_pkg::COORD_W'(col_ff);
      if (alpha_ff) begin
         pix_rsp.red   = held_ff[23:16];
         pix_rsp.alpha = cmd_head.data;
      end else begin
         pix_rsp.red   = cmd_head.data;
         pix_rsp.alpha = 8'd0;
      end

      done_rsp       = '0;
      done_rsp.kind  = bpsd_pkg::KIND_DONE;
      done_rsp.err   = bpsd_pkg::ERR_NONE;

      trunc_rsp      = '0;
      trunc_rsp.kind = bpsd_pkg::KIND_ERROR;
      trunc_rsp.err  = bpsd_pkg::ERR_TRUNC;

      err_rsp        = '0;
      err_rsp.kind   = bpsd_pkg::KIND_ERROR;
      err_rsp.err    = cmd_head.err;
   end

   // Command execution
   always_comb begin
      active_in = active_ff;
      wm1_in    = wm1_ff;
      hm1_in    = hm1_ff;
      alpha_in  = alpha_ff;
      bip_in    = bip_ff;
      held_in   = held_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pad_in    = pad_ff;
      rsp_wr    = '0;
      if (cmd_pop) begin
         case (cmd_head.op)
            bpsd_pkg::OP_START: begin
               active_in = 1'b1;
               wm1_in    = cmd_head.wm1;
               hm1_in    = cmd_head.hm1;
               alpha_in  = cmd_head.alpha;
               bip_in    = '0;
               held_in   = '0;
               col_in    = '0;
               row_in    = '0;
               pad_in    = '0;
            end
            bpsd_pkg::OP_ERROR: begin
               rsp_wr.count = 2'd1;
               rsp_wr.first = err_rsp;
               active_in    = 1'b0;
            end
            bpsd_pkg::OP_PIXEL: begin
               if (active_ff) begin
                  if (pad_ff != 2'd0) begin
                     pad_in = pad_ff - 2'd1;
                  end else if (bip_ff != (alpha_ff ? 2'd3 : 2'd2)) begin
                     held_in[{bip_ff, 3'b000} +: 8] = cmd_head.data;
                     bip_in = bip_ff + 2'd1;
                  end else begin
                     rsp_wr.count = 2'd1;
                     rsp_wr.first = pix_rsp;
                     bip_in       = '0;
                     held_in      = '0;
                     if (col_ff == wm1_ff) begin
                        // row finished: wrap column, set up padding
                        col_in = '0;
                        row_in = row_ff + 1'b1;
                        pad_in = alpha_ff ? 2'd0 : 2'(wm1_ff) + 2'd1;
                        if (row_ff == hm1_ff) begin
                           rsp_wr.count  = 2'd2;
                           rsp_wr.second = done_rsp;
                           active_in     = 1'b0;
                        end
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  // file ended before the last pixel
                  if (cmd_head.eof && active_in) begin
                     if (rsp_wr.count == 2'd0) rsp_wr.first = trunc_rsp;
                     else                      rsp_wr.second = trunc_rsp;
                     rsp_wr.count = rsp_wr.count + 2'd1;
                  end
               end
               if (cmd_head.eof) active_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) active_ff <= 1'b0;
      else       active_ff <= active_in;
   end

   always_ff @(posedge clock) begin
      wm1_ff   <= wm1_in;
      hm1_ff   <= hm1_in;
      alpha_ff <= alpha_in;
      bip_ff   <= bip_in;
      held_ff  <= held_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      pad_ff   <= pad_in;
   end

endmodule

// ===== src/bpsd_rsp_fifo.sv =====
// Result queue: takes up to two results per cycle, delivers one.
module bpsd_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  bpsd_pkg::rsp_push_type rsp_wr,
   output logic                   room,
   input  logic                   pop,
   output logic                   empty,
   output bpsd_pkg::rsp_type      head
);

   bpsd_pkg::rsp_type entry_ff [bpsd_pkg::RSP_DEPTH];
   logic [bpsd_pkg::RSP_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bpsd_pkg::RSP_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bpsd_pkg::RSP_CW-1:0] count_ff, count_in;
   logic [bpsd_pkg::RSP_AW-1:0] wr_next;
   logic do_pop;

   // room for two results, the most one transaction can produce
   assign room    = (count_ff <= bpsd_pkg::RSP_CW'(bpsd_pkg::RSP_DEPTH - 2));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_pop  = pop && !empty;
   assign wr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + bpsd_pkg::RSP_AW'(rsp_wr.count);
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + bpsd_pkg::RSP_CW'(rsp_wr.count)
                  - bpsd_pkg::RSP_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, two write slots
   always_ff @(posedge clock) begin
      if (rsp_wr.count != 2'd0) entry_ff[wr_ptr_ff] <= rsp_wr.first;
      if (rsp_wr.count == 2'd2) entry_ff[wr_next]   <= rsp_wr.second;
   end

endmodule

// ===== src/bpsd_checker.sv =====
// Port-level checks on the decoder's result stream, bound to the top level.
module bpsd_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_empty,
   input logic [1:0]   rsp_result_kind,
   input logic [2:0]   rsp_error_code,
   input logic [7:0]   rsp_red,
   input logic [7:0]   rsp_green,
   input logic [7:0]   rsp_blue,
   input logic [7:0]   rsp_alpha,
   input logic         rsp_has_alpha,
   input logic [11:0]  rsp_out_row,
   input logic [11:0]  rsp_out_col
);

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // Pixels carry no error code
   a_pixel_no_err: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind == bpsd_pkg::KIND_PIXEL) |->
      rsp_error_code == bpsd_pkg::ERR_NONE)
      else $error("pixel result with error code");

   // Error results carry a nonzero code
   a_error_code: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind == bpsd_pkg::KIND_ERROR) |->
      rsp_error_code != bpsd_pkg::ERR_NONE)
      else $error("error result without code");

   // Completion and error results have all pixel fields cleared
   a_status_clear: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind != bpsd_pkg::KIND_PIXEL) |->
      (rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0 && rsp_alpha == 8'd0 &&
       !rsp_has_alpha && rsp_out_row == 12'd0 && rsp_out_col == 12'd0))
      else $error("status result with pixel fields set");

   // 24-bit pixels report zero alpha
   a_rgb_alpha: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind == bpsd_pkg::KIND_PIXEL && !rsp_has_alpha) |->
      rsp_alpha == 8'd0)
      else $error("24-bit pixel with nonzero alpha");

endmodule

bind bmp_pixel_stream_decoder_core bpsd_checker u_bpsd_checker (.*);
